// ----- hw/rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared constants, codes and record types of the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Width of the internal byte counters; the count ports stay PORT_W wide.
  localparam int COUNT_W    = 32;
  localparam int PORT_W     = 32;
  localparam int PADDR_W    = 3;
  localparam int CMDQ_DEPTH = 4;

  localparam logic [7:0] PAD_CHAR  = 8'd61;
  localparam logic [7:0] ALPHA_TOP = 8'd122;

  // Character classes produced by the front end.
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_SYM  = 2'd1;
  localparam logic [1:0] CLS_PAD  = 2'd2;
  localparam logic [1:0] CLS_BAD  = 2'd3;

  // Decode modes.
  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_STRICT = 2'd2;
  localparam logic [1:0] MODE_UNDEF  = 2'd3;

  // Final status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Register indexes (paddr[2]).
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  typedef logic [COUNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [5:0] val;
    logic       eos;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PORT_W-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic [1:0] status;
    cnt_t       dec;
    cnt_t       con;
    logic       last;
  } res_t;

endpackage

// ----- hw/rtl/b64d_regs.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder configuration registers
// APB-style register file holding the decode mode and the output capacity.
// ----------------------------------------------------------------------------
module b64d_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [b64d_pkg::PADDR_W-1:0] paddr,
  input  logic [b64d_pkg::PORT_W-1:0]  pwdata,
  output logic [b64d_pkg::PORT_W-1:0]  prdata,
  output logic                         pready,
  output b64d_pkg::cfg_t               cfg
);
  import b64d_pkg::*;

  logic [1:0]        mode_r;
  logic [PORT_W-1:0] cap_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STOP;
      cap_r  <= '1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE: mode_r <= pwdata[1:0];
        REG_CAP:  cap_r  <= pwdata;
        default:  cap_r  <= cap_r;
      endcase
    end
  end

  assign prdata   = (paddr[2] == REG_CAP) ? cap_r : PORT_W'(mode_r);
  assign cfg.mode = mode_r;
  assign cfg.cap  = cap_r;

endmodule

// ----- hw/rtl/b64d_front.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Accepts text requests and classifies each byte into a command record.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic           push,
  output logic           full,
  input  logic [7:0]     in_text_byte,
  input  logic           in_byte_present,
  input  logic           in_end_of_string,
  input  logic           q_full,
  output logic           q_wr,
  output b64d_pkg::cmd_t q_wdata
);
  import b64d_pkg::*;

  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LO_A  = 8'd97;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_SLASH = 8'd47;

  logic [7:0] c;

  assign c    = in_text_byte;
  assign full = q_full;
  assign q_wr = push & ~q_full;

  always_comb begin
    q_wdata.cls = CLS_BAD;
    q_wdata.val = '0;
    q_wdata.eos = in_end_of_string;
    if (!in_byte_present) begin
      q_wdata.cls = CLS_NONE;
    end else if (c > ALPHA_TOP) begin
      q_wdata.cls = CLS_BAD;
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      q_wdata.cls = CLS_SYM;
      q_wdata.val = 6'(c - CH_UP_A);
    end else if (c inside {[CH_LO_A:ALPHA_TOP]}) begin
      // Lower case letters map to 26..51.
      q_wdata.cls = CLS_SYM;
      q_wdata.val = 6'(c - CH_LO_A + 8'd26);
    end else if (c inside {[CH_ZERO:CH_NINE]}) begin
      q_wdata.cls = CLS_SYM;
      q_wdata.val = 6'(c - CH_ZERO + 8'd52);
    end else if (c == CH_PLUS) begin
      q_wdata.cls = CLS_SYM;
      q_wdata.val = 6'd62;
    end else if (c == CH_SLASH) begin
      q_wdata.cls = CLS_SYM;
      q_wdata.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      q_wdata.cls = CLS_PAD;
    end
  end

endmodule

// ----- hw/rtl/b64d_cmdq.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder command queue
// Short FIFO of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module b64d_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b64d_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output b64d_pkg::cmd_t rd_data,
  output logic           full,
  output logic           not_empty
);
  import b64d_pkg::*;

  localparam int AW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_r [CMDQ_DEPTH];
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign full      = (cnt_r == CW'(CMDQ_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en & ~full;
  assign do_rd     = rd_en & not_empty;
  assign rd_data   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == AW'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == AW'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/b64d_back.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Runs the quad state, counters and status decisions for each command and
// sequences the resulting bytes and status one per cycle into the output
// register while that register is free or being popped.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64d_pkg::cfg_t cfg,
  input  b64d_pkg::cmd_t cmd,
  input  logic           cmd_avail,
  output logic           cmd_take,
  input  logic           res_pop,
  output logic           res_valid,
  output b64d_pkg::res_t res
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n_data;
    logic [1:0]      status;
    cnt_t            dec;
    cnt_t            con;
    logic [1:0]      last_idx;
  } plan_t;

  // Per-string state.
  logic [3:0][5:0] qv_r, qv_nxt, qv1;
  logic [1:0]      fill_r, fill_nxt, fill_pre;
  logic [2:0]      pad_r, pad_nxt, pad1;
  cnt_t            skip_r, skip_nxt;
  cnt_t            dec_r, dec_nxt;
  cnt_t            con_r, con_nxt;
  logic            halted_r, halted_nxt;
  logic [1:0]      hstat_r, hstat_nxt;

  // Result sequencer and output register.
  plan_t           plan_r, plan_nxt;
  logic            plan_valid_r, plan_valid_nxt;
  logic [1:0]      idx_r, idx_nxt;
  res_t            out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Decision terms.
  logic             act, is_bad, take, complete, part_try, fits, upd, dec_zero;
  logic             halt_pre, halt_fin;
  logic [1:0]       hstat_pre, hstat_fin;
  logic [1:0]       n_quad, n_part, n_sel, n_data, st;
  logic [2:0]       total;
  logic [COUNT_W:0] dec_sum;
  logic [COUNT_W+1:0] con_sum;
  cnt_t             dec_new, con_new, dec_upd, con_upd, con_add;
  logic [2:0]       con_inc;
  logic [2:0][7:0]  bytes;
  logic             out_rdy, emit, plan_last;
  res_t             cur;

  always_comb begin
    act    = (cmd.cls != CLS_NONE) && !halted_r && (cfg.mode != MODE_UNDEF);
    is_bad = act && (cmd.cls == CLS_BAD);
    take   = act && ((cmd.cls == CLS_SYM) || (cmd.cls == CLS_PAD));

    pad1 = (act && (cmd.cls == CLS_PAD) && (pad_r != 3'd7)) ? pad_r + 3'd1 : pad_r;

    qv1 = qv_r;
    if (take) begin
      qv1[fill_r] = (cmd.cls == CLS_SYM) ? cmd.val : 6'd0;
    end

    complete = take && (fill_r == 2'd3);
    fill_pre = (take && !complete) ? fill_r + 2'd1 : fill_r;
    n_quad   = (pad1 >= 3'd3) ? 2'd0 : 2'(3'd3 - pad1);
    n_part   = (fill_pre == 2'd3) ? 2'd2 : 2'd1;

    halt_pre  = halted_r | (is_bad && (cfg.mode != MODE_SKIP));
    hstat_pre = (is_bad && (cfg.mode == MODE_STRICT)) ? ST_ERR : hstat_r;

    part_try = cmd.eos && !complete && (cfg.mode != MODE_UNDEF) &&
               (cfg.mode != MODE_SKIP) && !(halt_pre && (hstat_pre != ST_OK)) &&
               (fill_pre != 2'd0);

    // One capacity check per command: a full quad or the partial last quad.
    n_sel   = complete ? n_quad : n_part;
    dec_sum = {1'b0, dec_r} + (COUNT_W+1)'(n_sel);
    fits    = (PORT_W+1)'(dec_sum) <= {1'b0, cfg.cap};
    dec_new = dec_sum[COUNT_W] ? '1 : dec_sum[COUNT_W-1:0];

    con_add = complete ? skip_r : '0;
    con_inc = complete ? 3'd4 : {1'b0, fill_pre};
    con_sum = (COUNT_W+2)'(con_r) + (COUNT_W+2)'(con_add) + (COUNT_W+2)'(con_inc);
    con_new = (con_sum[COUNT_W+1:COUNT_W] != 2'b00) ? '1 : con_sum[COUNT_W-1:0];

    upd      = (complete || part_try) && fits;
    dec_upd  = upd ? dec_new : dec_r;
    con_upd  = upd ? con_new : con_r;
    dec_zero = (dec_r == '0) && (!upd || (n_sel == 2'd0));

    halt_fin  = halt_pre | (complete && !fits);
    hstat_fin = (complete && !fits) ? ST_FULL : hstat_pre;

    if (cfg.mode == MODE_UNDEF) begin
      st = ST_ERR;
    end else if (halt_fin && (hstat_fin != ST_OK)) begin
      st = hstat_fin;
    end else if (cfg.mode != MODE_SKIP) begin
      st = (part_try && !fits) ? ST_FULL : (dec_zero ? ST_ERR : ST_OK);
    end else begin
      st = ST_OK;
    end

    if (complete && fits) begin
      n_data = n_quad;
    end else if (part_try && fits) begin
      n_data = n_part;
    end else begin
      n_data = 2'd0;
    end
    total = 3'(n_data) + 3'(cmd.eos);

    bytes[0] = {qv1[0], qv1[1][5:4]};
    bytes[1] = {qv1[1][3:0], qv1[2][5:2]};
    bytes[2] = {qv1[2][1:0], qv1[3]};
  end

  // Handshake between sequencer, command queue and output register.
  assign out_rdy   = ~out_valid_r | res_pop;
  assign emit      = plan_valid_r & out_rdy;
  assign plan_last = (idx_r == plan_r.last_idx);
  assign cmd_take  = cmd_avail & (~plan_valid_r | (emit & plan_last));

  always_comb begin
    cur.kind   = KIND_DATA;
    cur.status = ST_OK;
    cur.dec    = plan_r.dec;
    cur.con    = plan_r.con;
    cur.last   = 1'b0;
    case (idx_r)
      2'd0:    cur.data = plan_r.bytes[0];
      2'd1:    cur.data = plan_r.bytes[1];
      default: cur.data = plan_r.bytes[2];
    endcase
    if (idx_r >= plan_r.n_data) begin
      cur.data   = 8'd0;
      cur.kind   = KIND_STATUS;
      cur.status = plan_r.status;
      cur.last   = 1'b1;
    end
  end

  always_comb begin
    qv_nxt         = qv_r;
    fill_nxt       = fill_r;
    pad_nxt        = pad_r;
    skip_nxt       = skip_r;
    dec_nxt        = dec_r;
    con_nxt        = con_r;
    halted_nxt     = halted_r;
    hstat_nxt      = hstat_r;
    plan_nxt       = plan_r;
    plan_valid_nxt = plan_valid_r;
    idx_nxt        = idx_r;

    if (emit) begin
      idx_nxt = idx_r + 2'd1;
      if (plan_last) begin
        plan_valid_nxt = 1'b0;
      end
    end

    if (cmd_take) begin
      plan_nxt.bytes    = bytes;
      plan_nxt.n_data   = n_data;
      plan_nxt.status   = st;
      plan_nxt.dec      = (cmd.eos && (st == ST_ERR)) ? '0 : dec_upd;
      plan_nxt.con      = con_upd;
      plan_nxt.last_idx = 2'(total - 3'd1);
      plan_valid_nxt    = (total != 3'd0);
      idx_nxt           = 2'd0;

      if (cmd.eos) begin
        qv_nxt     = '0;
        fill_nxt   = 2'd0;
        pad_nxt    = 3'd0;
        skip_nxt   = '0;
        dec_nxt    = '0;
        con_nxt    = '0;
        halted_nxt = 1'b0;
        hstat_nxt  = ST_OK;
      end else begin
        qv_nxt     = (complete && fits) ? '0 : qv1;
        fill_nxt   = (complete && fits) ? 2'd0 : fill_pre;
        pad_nxt    = (complete && fits) ? 3'd0 : pad1;
        if (complete && fits) begin
          skip_nxt = '0;
        end else if (is_bad && (cfg.mode == MODE_SKIP) && (skip_r != '1)) begin
          skip_nxt = skip_r + 1'b1;
        end
        dec_nxt    = dec_upd;
        con_nxt    = con_upd;
        halted_nxt = halt_fin;
        hstat_nxt  = hstat_fin;
      end
    end

    out_nxt       = emit ? cur : out_r;
    out_valid_nxt = emit | (out_valid_r & ~res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r         <= '0;
      fill_r       <= 2'd0;
      pad_r        <= 3'd0;
      skip_r       <= '0;
      dec_r        <= '0;
      con_r        <= '0;
      halted_r     <= 1'b0;
      hstat_r      <= ST_OK;
      plan_valid_r <= 1'b0;
      idx_r        <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      qv_r         <= qv_nxt;
      fill_r       <= fill_nxt;
      pad_r        <= pad_nxt;
      skip_r       <= skip_nxt;
      dec_r        <= dec_nxt;
      con_r        <= con_nxt;
      halted_r     <= halted_nxt;
      hstat_r      <= hstat_nxt;
      plan_valid_r <= plan_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
    out_r  <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

// ----- hw/rtl/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes base64 text, one byte per request, into data bytes and a final
// status per string.
// ----------------------------------------------------------------------------
// The decoder takes one text byte per input request and, as each group of four
// characters completes, returns up to three decoded data bytes as separate
// result requests; a request with in_end_of_string set is followed by one
// status result (out_kind 1, out_last 1) carrying the final decoded and
// consumed counts. Input requests are accepted one per cycle while the queue
// is not full, into a four-deep command queue; the back end retires one
// request per cycle if each yields at most one result, because results leave
// one per cycle, while popped, through a single output register. A request
// completing a quad holds the back end until its results (up to three, four
// with the status) have left, and the queue absorbs the text bytes arriving
// meanwhile. A request passes the queue, plan and output registers before its
// first result. The mode and capacity registers must only be written while no
// string is in flight; there is no initialization sweep after reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  // Text input
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_text_byte,
  input  logic                         in_byte_present,
  input  logic                         in_end_of_string,
  // Results
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         out_kind,
  output logic [1:0]                   out_status,
  output logic [b64d_pkg::PORT_W-1:0]  out_decoded_total,
  output logic [b64d_pkg::PORT_W-1:0]  out_consumed_total,
  output logic                         out_last,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [b64d_pkg::PADDR_W-1:0] paddr,
  input  logic [b64d_pkg::PORT_W-1:0]  pwdata,
  output logic [b64d_pkg::PORT_W-1:0]  prdata,
  output logic                         pready
);
  import b64d_pkg::*;

  cfg_t cfg;
  cmd_t q_wdata;
  cmd_t q_rdata;
  res_t res;
  logic q_full;
  logic q_wr;
  logic q_not_empty;
  logic q_rd;
  logic res_valid;

  b64d_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end: classify each text byte as a symbol, a pad, an invalid byte
  // or an empty end marker.
  b64d_front u_front (
    .push             (push),
    .full             (full),
    .in_text_byte     (in_text_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_wr             (q_wr),
    .q_wdata          (q_wdata)
  );

  // The queue lets text keep flowing while the back end emits a quad.
  b64d_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr),
    .wr_data   (q_wdata),
    .rd_en     (q_rd),
    .rd_data   (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back end: quad assembly, counters, capacity checks and result ordering.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (q_rdata),
    .cmd_avail (q_not_empty),
    .cmd_take  (q_rd),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty              = ~res_valid;
  assign out_byte           = res.data;
  assign out_kind           = res.kind;
  assign out_status         = res.status;
  assign out_decoded_total  = PORT_W'(res.dec);
  assign out_consumed_total = PORT_W'(res.con);
  assign out_last           = res.last;

endmodule

// ----- hw/rtl/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder port checker
// Concurrent checks on the decoder's result ports, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic [7:0]                  out_byte,
  input logic                        out_kind,
  input logic [1:0]                  out_status,
  input logic [b64d_pkg::PORT_W-1:0] out_decoded_total,
  input logic                        out_last
);
  import b64d_pkg::*;

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result offered right after reset");

  // Only the status result closes a string.
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_last == out_kind))
    else $error("last flag does not match result kind");

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_DATA)) |-> (out_status == ST_OK))
    else $error("data result carries a nonzero status");

  // A failed string reports nothing decoded.
  a_error_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_STATUS) && (out_status == ST_ERR))
      |-> (out_decoded_total == '0))
    else $error("error status with nonzero decoded count");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_kind) &&
                          $stable(out_last)))
    else $error("waiting result changed or vanished");

endmodule

bind base64_stream_decoder b64d_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_byte          (out_byte),
  .out_kind          (out_kind),
  .out_status        (out_status),
  .out_decoded_total (out_decoded_total),
  .out_last          (out_last)
);
